[src/tentative_pool_admission_and_ban_top_macros.svh]
// Assertion macros shared by the admission and ban block.
`ifndef TENTATIVE_POOL_ADMISSION_AND_BAN_TOP_MACROS_SVH
`define TENTATIVE_POOL_ADMISSION_AND_BAN_TOP_MACROS_SVH
`ifndef SYNTH
// Checks that prop holds at every clock edge out of reset.
`define TPAB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tpab check failed");
// Checks that cond at one edge is followed by nxt at the next edge.
`define TPAB_ASSERT_NEXT(lbl, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("tpab sequence check failed");
`else
`define TPAB_ASSERT(lbl, prop)
`define TPAB_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

[src/tpab_pkg.sv]
// Package with the types and constants of the admission and ban block.
package tpab_pkg;

  localparam int NUM_POOLS_DEF  = 8;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int POOL_W   = 3;
  localparam int DUR_W    = 40;
  localparam int TIME_W   = 48;
  localparam int SUM_W    = 48;
  localparam int DVD_W    = 49;
  localparam int SAMPLE_W = 10;
  localparam int RATIO_W  = 16;
  localparam int PROD_W   = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam int MAX_REPORTS = 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_RST = 10'd10;
  localparam logic [RATIO_W-1:0]  RATIO_RST  = 16'd512;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY  = 2'd0,
    CMD_START  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 2'd0,
    REG_MAX_RATIO    = 2'd1,
    REG_MIN_DURATION = 2'd2,
    REG_TENT_DISABLE = 2'd3
  } reg_idx_t;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BCHK,
    ST_BDIV,
    ST_THR,
    ST_SCAN,
    ST_PDIV,
    ST_PCMP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [POOL_W-1:0] pool;
    logic              tentative;
    logic              finished_completed;
    logic [DUR_W-1:0]  job_duration;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic              allowed;
    logic [POOL_W-1:0] banned_pool;
    logic              last;
  } out_item_t;

endpackage

[src/tentative_pool_admission_and_ban_top.sv]
// Top level: admission control and slow-pool banning for tentative pools.
// A query returns one answer; a start returns nothing. A finish that completes a job
// runs one shared restoring divider, one quotient bit per cycle, first for the
// baseline average once enough baseline samples exist and then, if that average
// is nonzero, once for each started, unbanned pool, visited in index order until
// the report limit is reached; other pools are skipped without a division. The
// block takes no new item until the previous one is finished; the result
// register lets a finished answer wait while the next item is accepted.
`include "tentative_pool_admission_and_ban_top_macros.svh"

module tentative_pool_admission_and_ban_top #(
  parameter int NUM_POOLS  = tpab_pkg::NUM_POOLS_DEF,
  parameter int COUNT_BITS = tpab_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tpab_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tpab_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpab_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int CW    = IW + 1;
  localparam int DNW   = COUNT_BITS + 1;
  localparam int SW    = COUNT_BITS + 2;
  localparam int DVD_W = tpab_pkg::DVD_W;
  localparam int SUM_W = tpab_pkg::SUM_W;
  localparam int DCW   = $clog2(DVD_W + 1);
  localparam int NRW   = $clog2(tpab_pkg::MAX_REPORTS + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0]      SUM_MAX = '1;

  // Configuration registers.
  logic [tpab_pkg::SAMPLE_W-1:0] sample_r;
  logic [tpab_pkg::RATIO_W-1:0]  ratio_r;
  logic [tpab_pkg::DUR_W-1:0]    min_dur_r;
  logic                          tdis_r;

  // Per-pool and baseline state.
  logic [COUNT_BITS-1:0]      started_r   [NUM_POOLS];
  logic [COUNT_BITS-1:0]      finished_r  [NUM_POOLS];
  logic [COUNT_BITS-1:0]      completed_r [NUM_POOLS];
  logic [SUM_W-1:0]           psum_r      [NUM_POOLS];
  logic [tpab_pkg::TIME_W-1:0] stamp_r    [NUM_POOLS];
  logic [NUM_POOLS-1:0]       banned_r;
  logic [SUM_W-1:0]           bsum_r;
  logic [COUNT_BITS-1:0]      bcnt_r;

  // Sequencer and datapath registers.
  tpab_pkg::state_t   state_r, state_nxt;
  tpab_pkg::in_item_t item_r;
  logic               pvalid_r;
  logic [CW-1:0]      idx_r;
  logic [DVD_W-1:0]   div_q_r;
  logic [DNW-1:0]     div_rem_r;
  logic [DNW-1:0]     div_den_r;
  logic [DCW-1:0]     div_cnt_r;
  logic [tpab_pkg::PROD_W-1:0] thr_r;
  logic               pend_v_r;
  logic [tpab_pkg::POOL_W-1:0] pend_pool_r;
  logic [NRW-1:0]     nrep_r;
  logic               out_valid_r;
  tpab_pkg::out_item_t out_data_r;

  // Selected entry of the per-pool state.
  logic [IW-1:0]         sel;
  logic [COUNT_BITS-1:0] st_rd, fi_rd, co_rd;
  logic [SUM_W-1:0]      ps_rd;
  logic [tpab_pkg::TIME_W-1:0] ts_rd;
  logic                  bn_rd;

  assign sel   = idx_r[IW-1:0];
  assign st_rd = started_r[sel];
  assign fi_rd = finished_r[sel];
  assign co_rd = completed_r[sel];
  assign ps_rd = psum_r[sel];
  assign ts_rd = stamp_r[sel];
  assign bn_rd = banned_r[sel];

  // Counter and sum helpers.
  function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] c);
    cnt_inc = (c == CNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] s,
                                               input logic [tpab_pkg::DUR_W-1:0] d);
    logic [SUM_W:0] r;
    r = {1'b0, s} + (SUM_W+1)'(d);
    sum_add = r[SUM_W] ? SUM_MAX : r[SUM_W-1:0];
  endfunction

  // Admission test for a tentative query.
  logic signed [SW-1:0] running, remaining;
  logic                 allow;
  assign running   = $signed(SW'(st_rd)) - $signed(SW'(fi_rd));
  assign remaining = $signed(SW'(sample_r)) - $signed(SW'(co_rd));
  always_comb begin
    allow = 1'b1;
    if (item_r.tentative) begin
      if (!pvalid_r || tdis_r || bn_rd) begin
        allow = 1'b0;
      end else if (remaining > 0 && running >= remaining) begin
        allow = 1'b0;
      end
    end
  end

  // Baseline gate and scan candidate.
  logic base_ok, cand, short_avg;
  logic [tpab_pkg::TIME_W-1:0] elapsed;
  logic [DVD_W-1:0] pdvd;
  assign base_ok   = (SW'(bcnt_r) >= SW'(sample_r)) && (bcnt_r != '0);
  assign cand      = (st_rd != '0) && !bn_rd;
  assign short_avg = (SW'(co_rd) < SW'(sample_r)) || (co_rd == '0);
  assign elapsed   = (item_r.now_time >= ts_rd) ? item_r.now_time - ts_rd : '0;
  assign pdvd      = short_avg ? DVD_W'(ps_rd) + DVD_W'(elapsed) : DVD_W'(ps_rd);

  // Restoring divider step, one quotient bit per cycle.
  logic [DNW:0]   rem_sh;
  logic           div_ge;
  logic [DNW:0]   rem_sub;
  assign rem_sh  = {div_rem_r, div_q_r[DVD_W-1]};
  assign div_ge  = rem_sh >= {1'b0, div_den_r};
  assign rem_sub = rem_sh - {1'b0, div_den_r};

  // Slow test on the pool average held in the quotient register.
  logic slow;
  assign slow = (div_q_r >= DVD_W'(min_dur_r)) &&
                ({7'd0, div_q_r, 8'd0} >= thr_r);

  logic scan_end;
  assign scan_end = (idx_r >= CW'(NUM_POOLS)) || (nrep_r == NRW'(tpab_pkg::MAX_REPORTS));

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpab_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tpab_pkg::ST_EXEC;
      end
      tpab_pkg::ST_EXEC: begin
        unique case (item_r.command)
          tpab_pkg::CMD_QUERY: if (out_free) state_nxt = tpab_pkg::ST_IDLE;
          tpab_pkg::CMD_FINISH: begin
            state_nxt = item_r.finished_completed ? tpab_pkg::ST_BCHK : tpab_pkg::ST_IDLE;
          end
          default: state_nxt = tpab_pkg::ST_IDLE;
        endcase
      end
      tpab_pkg::ST_BCHK: state_nxt = base_ok ? tpab_pkg::ST_BDIV : tpab_pkg::ST_IDLE;
      tpab_pkg::ST_BDIV: if (div_cnt_r == DCW'(1)) state_nxt = tpab_pkg::ST_THR;
      tpab_pkg::ST_THR: begin
        state_nxt = (div_q_r == '0) ? tpab_pkg::ST_IDLE : tpab_pkg::ST_SCAN;
      end
      tpab_pkg::ST_SCAN: begin
        if (scan_end) state_nxt = tpab_pkg::ST_FLUSH;
        else if (cand) state_nxt = tpab_pkg::ST_PDIV;
      end
      tpab_pkg::ST_PDIV: if (div_cnt_r == DCW'(1)) state_nxt = tpab_pkg::ST_PCMP;
      tpab_pkg::ST_PCMP: begin
        if (!(slow && pend_v_r && !out_free)) state_nxt = tpab_pkg::ST_SCAN;
      end
      tpab_pkg::ST_FLUSH: begin
        if (!pend_v_r || out_free) state_nxt = tpab_pkg::ST_IDLE;
      end
      default: state_nxt = tpab_pkg::ST_IDLE;
    endcase
  end

  // Output decode: handshake and result register load.
  logic                out_load;
  tpab_pkg::out_item_t out_nxt;
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    out_nxt  = '0;
    unique case (state_r)
      tpab_pkg::ST_IDLE: in_ready = 1'b1;
      tpab_pkg::ST_EXEC: begin
        if (item_r.command == tpab_pkg::CMD_QUERY && out_free) begin
          out_load            = 1'b1;
          out_nxt.result_kind = tpab_pkg::KIND_ANSWER;
          out_nxt.allowed     = allow;
          out_nxt.last        = 1'b1;
        end
      end
      tpab_pkg::ST_PCMP: begin
        if (slow && pend_v_r && out_free) begin
          out_load            = 1'b1;
          out_nxt.result_kind = tpab_pkg::KIND_REPORT;
          out_nxt.banned_pool = pend_pool_r;
        end
      end
      tpab_pkg::ST_FLUSH: begin
        if (pend_v_r && out_free) begin
          out_load            = 1'b1;
          out_nxt.result_kind = tpab_pkg::KIND_REPORT;
          out_nxt.banned_pool = pend_pool_r;
          out_nxt.last        = 1'b1;
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpab_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      nrep_r      <= '0;
      sample_r    <= tpab_pkg::SAMPLE_RST;
      ratio_r     <= tpab_pkg::RATIO_RST;
      min_dur_r   <= '0;
      tdis_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          tpab_pkg::REG_SAMPLE_COUNT: sample_r  <= cfg_data[tpab_pkg::SAMPLE_W-1:0];
          tpab_pkg::REG_MAX_RATIO:    ratio_r   <= cfg_data[tpab_pkg::RATIO_W-1:0];
          tpab_pkg::REG_MIN_DURATION: min_dur_r <= cfg_data;
          tpab_pkg::REG_TENT_DISABLE: tdis_r    <= cfg_data[0];
          default: tdis_r <= tdis_r;
        endcase
      end
      if (state_r == tpab_pkg::ST_THR) begin
        nrep_r   <= '0;
        pend_v_r <= 1'b0;
      end
      if (state_r == tpab_pkg::ST_PCMP && state_nxt == tpab_pkg::ST_SCAN && slow) begin
        pend_v_r <= 1'b1;
        nrep_r   <= nrep_r + NRW'(1);
      end
      if (state_r == tpab_pkg::ST_FLUSH && out_free) pend_v_r <= 1'b0;
    end
  end

  // Per-pool and baseline state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        started_r[i]   <= '0;
        finished_r[i]  <= '0;
        completed_r[i] <= '0;
        psum_r[i]      <= '0;
      end
      banned_r <= '0;
      bsum_r   <= '0;
      bcnt_r   <= '0;
    end else begin
      if (state_r == tpab_pkg::ST_EXEC) begin
        if (item_r.command == tpab_pkg::CMD_START && item_r.tentative && pvalid_r) begin
          started_r[sel] <= cnt_inc(st_rd);
        end
        if (item_r.command == tpab_pkg::CMD_FINISH) begin
          if (item_r.tentative && pvalid_r) begin
            finished_r[sel] <= cnt_inc(fi_rd);
            if (item_r.finished_completed) begin
              completed_r[sel] <= cnt_inc(co_rd);
              psum_r[sel]      <= sum_add(ps_rd, item_r.job_duration);
            end
          end
          if (!item_r.tentative && item_r.finished_completed) begin
            bcnt_r <= cnt_inc(bcnt_r);
            bsum_r <= sum_add(bsum_r, item_r.job_duration);
          end
        end
      end
      if (state_r == tpab_pkg::ST_PCMP && state_nxt == tpab_pkg::ST_SCAN && slow) begin
        banned_r[sel] <= 1'b1;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= out_nxt;
    unique case (state_r)
      tpab_pkg::ST_IDLE: begin
        item_r   <= in_data;
        pvalid_r <= ({4'd0, in_data.pool} < 7'(NUM_POOLS));
        idx_r    <= ({4'd0, in_data.pool} < 7'(NUM_POOLS)) ? CW'(in_data.pool) : '0;
      end
      tpab_pkg::ST_EXEC: begin
        if (item_r.command == tpab_pkg::CMD_START && item_r.tentative && pvalid_r) begin
          stamp_r[sel] <= item_r.now_time;
        end
      end
      tpab_pkg::ST_BCHK: begin
        div_q_r   <= DVD_W'(bsum_r);
        div_rem_r <= '0;
        div_den_r <= DNW'(bcnt_r);
        div_cnt_r <= DCW'(DVD_W);
      end
      tpab_pkg::ST_BDIV, tpab_pkg::ST_PDIV: begin
        div_q_r   <= {div_q_r[DVD_W-2:0], div_ge};
        div_rem_r <= div_ge ? rem_sub[DNW-1:0] : rem_sh[DNW-1:0];
        div_cnt_r <= div_cnt_r - DCW'(1);
      end
      tpab_pkg::ST_THR: begin
        thr_r <= tpab_pkg::PROD_W'(ratio_r * div_q_r[SUM_W-1:0]);
        idx_r <= '0;
      end
      tpab_pkg::ST_SCAN: begin
        if (!scan_end) begin
          if (cand) begin
            div_q_r   <= pdvd;
            div_rem_r <= '0;
            div_den_r <= short_avg ? DNW'(co_rd) + DNW'(1) : DNW'(co_rd);
            div_cnt_r <= DCW'(DVD_W);
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
      end
      tpab_pkg::ST_PCMP: begin
        if (state_nxt == tpab_pkg::ST_SCAN) begin
          idx_r <= idx_r + CW'(1);
          if (slow) pend_pool_r <= tpab_pkg::POOL_W'(idx_r);
        end
      end
      default: pvalid_r <= pvalid_r;
    endcase
  end

  // A pending report only exists while the scan is running or flushing.
  logic scan_busy;
  assign scan_busy = (state_r == tpab_pkg::ST_SCAN) || (state_r == tpab_pkg::ST_PDIV) ||
                     (state_r == tpab_pkg::ST_PCMP) || (state_r == tpab_pkg::ST_FLUSH);

  // Checks on the sequencer.
  `TPAB_ASSERT(a_pend_in_scan, !pend_v_r || scan_busy)
  `TPAB_ASSERT(a_nrep_bound, nrep_r <= NRW'(tpab_pkg::MAX_REPORTS))
  `TPAB_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)

endmodule
